/* sv/nmea_rmc_pkg.sv */
package nmea_rmc_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned HourW = 5;
	localparam int unsigned MinW = 7;
	localparam int unsigned SecW = 7;
	localparam int unsigned OffHourW = 5;
	localparam int unsigned OffMinW = 6;
	localparam int unsigned CfgDataW = 6;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned DigitW = 7;
	localparam int unsigned HdrPosW = 3;
	localparam int unsigned FieldW = 2;
	localparam int unsigned CountW = 3;

	localparam logic [OffHourW-1:0] OFFSET_HOURS_RST = 5'd3;
	localparam logic [OffMinW-1:0] OFFSET_MINUTES_RST = 6'd30;

	localparam logic [CfgIdxW-1:0] REG_OFFSET_HOURS = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFSET_MINUTES = 1'd1;

	localparam logic [FieldW-1:0] FIELD_HEADER = 2'd0;
	localparam logic [FieldW-1:0] FIELD_TIME = 2'd1;
	localparam logic [FieldW-1:0] FIELD_DONE = 2'd2;

	localparam logic [ByteW-1:0] CHAR_DOLLAR = 8'h24;
	localparam logic [ByteW-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [ByteW-1:0] CHAR_ZERO = 8'h30;

	localparam logic [HdrPosW-1:0] HDR_LEN = 3'd6;
	localparam logic [CountW-1:0] TIME_DIGITS = 3'd6;
	localparam logic [CountW-1:0] HOUR_END = 3'd2;
	localparam logic [CountW-1:0] MINUTE_END = 3'd4;
	localparam logic [7:0] MINUTE_MAX = 8'd59;
	localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;

	// Expected character of "$GPRMC" at a given header position.
	function automatic logic [ByteW-1:0] hdr_char(input logic [HdrPosW-1:0] pos);
		logic [ByteW-1:0] ch;
		case (pos)
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			default: ch = CHAR_DOLLAR;
		endcase
		return ch;
	endfunction

	// Remainder modulo 24 for values below 144.
	function automatic logic [HourW-1:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		if (v >= 8'd120) begin
			r = v - 8'd120;
		end else if (v >= 8'd96) begin
			r = v - 8'd96;
		end else if (v >= 8'd72) begin
			r = v - 8'd72;
		end else if (v >= 8'd48) begin
			r = v - 8'd48;
		end else if (v >= 8'd24) begin
			r = v - 8'd24;
		end else begin
			r = v;
		end
		return r[HourW-1:0];
	endfunction

	// One decimal digit appended to a 7-bit accumulator, kept to 7 bits.
	function automatic logic [DigitW-1:0] push_digit(input logic [DigitW-1:0] acc,
		input logic [3:0] d);
		logic [10:0] t;
		t = 11'(acc) * 11'd10 + 11'(d);
		return t[DigitW-1:0];
	endfunction

endpackage

/* sv/nmea_rmc_local_time_extractor_unit.sv */
// NMEA RMC local time extractor.
//
// The input channel (in_valid, in_stall, rx_byte) carries one character of
// the receiver's sentence stream per transfer. After "$GPRMC," the first
// six characters of the time field are taken as hhmmss. The comma closing
// that field produces one transfer on the output channel (out_valid,
// out_stall) with the local hour and minute after the configured offset,
// the seconds as received, and parse_status set when the field was short
// or held a non-digit. All other bytes produce no output.
// The block takes one byte per cycle while in_stall is low. A byte waits
// in the input register; its result loads the output register when free.
// When the receiver stalls, the finished result holds in the output
// register while bytes that produce no result keep flowing; only a second
// closing comma waits in the input register, and in_stall rises then.
// Offsets are written through cfg_we, cfg_index and cfg_data while idle;
// the user is bound to this, and the block itself does not enforce it.
// Reset clears the parser to wait for a dollar sign, empties both
// registers and loads the offsets with +3 hours and 30 minutes.
module nmea_rmc_local_time_extractor_unit
	import nmea_rmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ByteW-1:0]    rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HourW-1:0]    local_hour,
	output logic [MinW-1:0]     local_minute,
	output logic [SecW-1:0]     utc_second,
	output logic                parse_status
);

	logic [OffHourW-1:0] offset_hours_q;
	logic [OffMinW-1:0]  offset_minutes_q;

	logic                valid_s1;
	logic [ByteW-1:0]    byte_s1;

	logic [HdrPosW-1:0]  hdr_pos_q, hdr_pos_d;
	logic [FieldW-1:0]   field_q, field_d;
	logic [CountW-1:0]   count_q, count_d;
	logic [DigitW-1:0]   hour_q, hour_d;
	logic [DigitW-1:0]   minute_q, minute_d;
	logic [DigitW-1:0]   second_q, second_d;
	logic                bad_q, bad_d;
	logic                result;

	logic                out_valid_q;
	logic [HourW-1:0]    hour_out_q;
	logic [MinW-1:0]     minute_out_q;
	logic [SecW-1:0]     second_out_q;
	logic                status_out_q;

	logic                out_free;
	logic                advance;
	logic                in_take;
	logic                out_load;

	logic                is_digit;
	logic [3:0]          digit;
	logic [7:0]          min_sum;
	logic                carry;
	logic [7:0]          min_adj;
	logic [7:0]          hour_sum;
	logic                status;

	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!result || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;
	assign out_load = advance && result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_hours_q <= OFFSET_HOURS_RST;
			offset_minutes_q <= OFFSET_MINUTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_HOURS: offset_hours_q <= cfg_data[OffHourW-1:0];
				REG_OFFSET_MINUTES: offset_minutes_q <= cfg_data[OffMinW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	assign is_digit = byte_s1 inside {[8'h30:8'h39]};
	assign digit = is_digit ? 4'(byte_s1 - CHAR_ZERO) : 4'd0;

	always_comb begin
		hdr_pos_d = hdr_pos_q;
		field_d = field_q;
		count_d = count_q;
		hour_d = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		bad_d = bad_q;
		result = 1'b0;
		if (byte_s1 == CHAR_DOLLAR) begin
			hdr_pos_d = 3'd1;
			field_d = FIELD_HEADER;
			count_d = '0;
			hour_d = '0;
			minute_d = '0;
			second_d = '0;
			bad_d = 1'b0;
		end else if (field_q == FIELD_HEADER) begin
			if (hdr_pos_q >= 3'd1 && hdr_pos_q < HDR_LEN) begin
				hdr_pos_d = (byte_s1 == hdr_char(hdr_pos_q)) ? hdr_pos_q + 3'd1 : 3'd0;
			end else begin
				if (hdr_pos_q == HDR_LEN && byte_s1 == CHAR_COMMA) begin
					field_d = FIELD_TIME;
					count_d = '0;
					hour_d = '0;
					minute_d = '0;
					second_d = '0;
					bad_d = 1'b0;
				end
				hdr_pos_d = 3'd0;
			end
		end else if (field_q == FIELD_TIME) begin
			if (byte_s1 == CHAR_COMMA) begin
				result = 1'b1;
				field_d = FIELD_DONE;
				count_d = '0;
				hour_d = '0;
				minute_d = '0;
				second_d = '0;
				bad_d = 1'b0;
			end else if (count_q < TIME_DIGITS) begin
				if (!is_digit) begin
					bad_d = 1'b1;
				end
				if (count_q < HOUR_END) begin
					hour_d = push_digit(hour_q, digit);
				end else if (count_q < MINUTE_END) begin
					minute_d = push_digit(minute_q, digit);
				end else begin
					second_d = push_digit(second_q, digit);
				end
				count_d = count_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= '0;
			field_q <= FIELD_HEADER;
			count_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			bad_q <= 1'b0;
		end else if (advance) begin
			hdr_pos_q <= hdr_pos_d;
			field_q <= field_d;
			count_q <= count_d;
			hour_q <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			bad_q <= bad_d;
		end
	end

	assign status = bad_q || (count_q < TIME_DIGITS);
	assign min_sum = 8'(minute_q) + 8'(offset_minutes_q);
	assign carry = min_sum > MINUTE_MAX;
	assign min_adj = carry ? min_sum - MINUTES_PER_HOUR : min_sum;
	assign hour_sum = 8'(hour_q) + 8'(offset_hours_q) + 8'(carry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_out_q <= status;
			hour_out_q <= status ? '0 : mod24(hour_sum);
			minute_out_q <= status ? '0 : min_adj[MinW-1:0];
			second_out_q <= status ? '0 : second_q;
		end
	end

	assign out_valid = out_valid_q;
	assign local_hour = hour_out_q;
	assign local_minute = minute_out_q;
	assign utc_second = second_out_q;
	assign parse_status = status_out_q;

	// Only a closing comma of the time field loads a result.
	a_load_on_comma: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (byte_s1 == CHAR_COMMA && field_q == FIELD_TIME))
		else $error("result loaded without a closing comma");

	// The input side only stalls behind a result that is itself stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall && result))
		else $error("input stalled without a blocked result");

	// A well formed result always carries a wrapped hour.
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_out_q) |-> (hour_out_q < 5'd24))
		else $error("local hour out of range");

	// The digit counter never runs past the six time characters.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= TIME_DIGITS)
		else $error("digit count overflow");

endmodule

/* bench/nmea_rmc_local_time_extractor_unit_test.sv */
`timescale 1ns / 100ps

module nmea_rmc_local_time_extractor_unit_test
	import nmea_rmc_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned BYTES_PER_SETTING = 210;
	localparam logic [8*6-1:0] SENTENCE_TAG = "$GPRMC";

	typedef struct packed {
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
		logic             status;
	} local_time_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_OFFSET_HOURS;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ByteW-1:0]    rx_byte = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [HourW-1:0]    local_hour;
	logic [MinW-1:0]     local_minute;
	logic [SecW-1:0]     utc_second;
	logic                parse_status;

	logic [ByteW-1:0] rx_queue[$];
	local_time_t      pending_times[$];
	logic             in_took = 1'b0;
	int unsigned      in_gap_pct = 6;
	int unsigned      out_gap_pct = 74;
	int unsigned      fed_bytes = 0;
	int unsigned      times_checked = 0;
	int unsigned      mismatches = 0;
	int unsigned      cycles = 0;

	logic [OffHourW-1:0] off_hours = OFFSET_HOURS_RST;
	logic [OffMinW-1:0]  off_minutes = OFFSET_MINUTES_RST;
	logic [HdrPosW-1:0]  hdr_pos = '0;
	logic [FieldW-1:0]   sect = FIELD_HEADER;
	logic [CountW-1:0]   n_taken = '0;
	logic [DigitW-1:0]   hh_acc = '0;
	logic [DigitW-1:0]   mm_acc = '0;
	logic [DigitW-1:0]   ss_acc = '0;
	logic                bad_char = 1'b0;

	nmea_rmc_local_time_extractor_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.local_hour   (local_hour),
		.local_minute (local_minute),
		.utc_second   (utc_second),
		.parse_status (parse_status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic clear_time_field();
		n_taken = '0;
		hh_acc = '0;
		mm_acc = '0;
		ss_acc = '0;
		bad_char = 1'b0;
	endtask

	// Tracks the sentence parser and queues the local time that a closing comma produces.
	task automatic parse_rx_byte(input logic [ByteW-1:0] c);
		local_time_t t;
		logic [3:0]  d;
		int unsigned mins;
		int unsigned carry;
		if (c == CHAR_DOLLAR) begin
			hdr_pos = 3'd1;
			sect = FIELD_HEADER;
			clear_time_field();
		end else if (sect == FIELD_HEADER) begin
			if (hdr_pos >= 3'd1 && hdr_pos <= 3'd5) begin
				hdr_pos = (c == SENTENCE_TAG[47 - 8*int'(hdr_pos) -: 8]) ?
					hdr_pos + 3'd1 : 3'd0;
			end else begin
				if (hdr_pos == HDR_LEN && c == CHAR_COMMA) begin
					sect = FIELD_TIME;
					clear_time_field();
				end
				hdr_pos = 3'd0;
			end
		end else if (sect == FIELD_TIME) begin
			if (c == CHAR_COMMA) begin
				t = '0;
				t.status = bad_char || n_taken < TIME_DIGITS;
				if (!t.status) begin
					mins = 32'(mm_acc) + 32'(off_minutes);
					carry = 0;
					if (mins > 32'(MINUTE_MAX)) begin
						mins = mins - 32'(MINUTES_PER_HOUR);
						carry = 1;
					end
					t.hour = HourW'((32'(hh_acc) + 32'(off_hours) + carry) % 32'd24);
					t.minute = MinW'(mins);
					t.second = ss_acc;
				end
				pending_times.push_back(t);
				sect = FIELD_DONE;
				clear_time_field();
			end else if (n_taken < TIME_DIGITS) begin
				d = 4'd0;
				if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
					d = 4'(c - CHAR_ZERO);
				end else begin
					bad_char = 1'b1;
				end
				if (n_taken < HOUR_END) begin
					hh_acc = DigitW'(32'(hh_acc) * 32'd10 + 32'(d));
				end else if (n_taken < MINUTE_END) begin
					mm_acc = DigitW'(32'(mm_acc) * 32'd10 + 32'(d));
				end else begin
					ss_acc = DigitW'(32'(ss_acc) * 32'd10 + 32'(d));
				end
				n_taken = n_taken + 3'd1;
			end
		end
	endtask

	always @(posedge clk) begin
		local_time_t want;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			parse_rx_byte(rx_byte);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_times.size() == 0) begin
				$error("unexpected time result: hour %0d minute %0d second %0d status %0d",
					local_hour, local_minute, utc_second, parse_status);
				mismatches++;
			end else begin
				want = pending_times.pop_front();
				times_checked++;
				if (local_hour !== want.hour) begin
					$error("local_hour: expected %0d, got %0d", want.hour, local_hour);
					mismatches++;
				end
				if (local_minute !== want.minute) begin
					$error("local_minute: expected %0d, got %0d", want.minute, local_minute);
					mismatches++;
				end
				if (utc_second !== want.second) begin
					$error("utc_second: expected %0d, got %0d", want.second, utc_second);
					mismatches++;
				end
				if (parse_status !== want.status) begin
					$error("parse_status: expected %0d, got %0d", want.status, parse_status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// A new byte is offered only once the previous transfer has completed.
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (rx_queue.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
				in_valid <= 1'b1;
				rx_byte <= rx_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < out_gap_pct);
	end

	function automatic logic [ByteW-1:0] rand_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [ByteW-1:0] plain_byte(input bit allow_digits);
		logic [ByteW-1:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CHAR_DOLLAR || b == CHAR_COMMA ||
			(!allow_digits && b >= CHAR_ZERO && b <= CHAR_ZERO + 8'd9));
		return b;
	endfunction

	task automatic push_byte(input logic [ByteW-1:0] b);
		rx_queue.push_back(b);
		fed_bytes++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	task automatic push_good_sentence();
		push_text("$GPRMC,");
		repeat (6) push_byte(rand_digit());
		repeat ($urandom_range(0, 3)) push_byte(plain_byte(1'b1));
		push_byte(CHAR_COMMA);
		// The rest of the sentence is ignored by the parser.
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 35)) | 8'h40);
	endtask

	task automatic queue_sentence();
		int unsigned kind;
		int unsigned spot;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			push_good_sentence();
		end else if (kind < 78) begin
			push_text("$GPRMC,");
			repeat ($urandom_range(0, 5)) push_byte(rand_digit());
			push_byte(CHAR_COMMA);
		end else if (kind < 86) begin
			push_text("$GPRMC,");
			spot = $urandom_range(0, 5);
			for (int i = 0; i < 6; i++) begin
				push_byte(i == spot ? plain_byte(1'b0) : rand_digit());
			end
			push_byte(CHAR_COMMA);
		end else if (kind < 92) begin
			spot = $urandom_range(1, 6);
			push_byte(CHAR_DOLLAR);
			for (int i = 1; i < 7; i++) begin
				if (i == spot) begin
					push_byte(plain_byte(1'b0));
				end else begin
					push_byte(i == 6 ? CHAR_COMMA : SENTENCE_TAG[47 - 8*i -: 8]);
				end
			end
			repeat (6) push_byte(rand_digit());
			push_byte(CHAR_COMMA);
		end else if (kind < 96) begin
			push_text("$GPRMC,");
			repeat ($urandom_range(0, 5)) push_byte(rand_digit());
			push_good_sentence();
		end else begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (rx_queue.size() != 0 || in_valid || pending_times.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_OFFSET_HOURS) begin
			off_hours = val[OffHourW-1:0];
		end else begin
			off_minutes = val[OffMinW-1:0];
		end
	endtask

	task automatic set_offsets(input logic [CfgDataW-1:0] h, input logic [CfgDataW-1:0] m);
		write_offset(REG_OFFSET_HOURS, h);
		write_offset(REG_OFFSET_MINUTES, m);
	endtask

	task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
		input logic [CfgDataW-1:0] h, input logic [CfgDataW-1:0] m);
		int unsigned first;
		in_gap_pct = in_pct;
		out_gap_pct = out_pct;
		for (int half = 0; half < 2; half++) begin
			if (half == 0) begin
				set_offsets(h, m);
			end else begin
				set_offsets(CfgDataW'($urandom_range(0, 63)), CfgDataW'($urandom_range(0, 63)));
			end
			first = fed_bytes;
			while (fed_bytes - first < BYTES_PER_SETTING) begin
				queue_sentence();
			end
			wait_drained();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_text("$GPRMC,123519.00,A,4807");
		push_text("$GPRMC,235959,");
		push_text("$GPRMC,000000,");
		push_text("$GPRMC,1234,");
		push_text("$GPRMC,12a519,");
		push_text("$GPRMC,12$GPRMC,101010,");
		push_text("$GPRMX,111111,");
		push_text("$GPRMCX,111111,");
		push_text("$GPRMC,,");
		push_byte(8'h00);
		push_byte(8'hFF);
		wait_drained();
		set_offsets(6'd0, 6'd0);
		push_text("$GPRMC,000000,");
		push_text("$GPRMC,235959,");
		wait_drained();
		set_offsets(6'd31, 6'd63);
		push_text("$GPRMC,995959,");
		push_text("$GPRMC,99:959,");
		wait_drained();

		run_phase(6, 74, 6'd23, 6'd59);
		run_phase(74, 6, 6'd0, 6'd0);
		run_phase(0, 0, 6'd31, 6'd63);

		$display("Fed %0d bytes of directed and random sentences; checked %0d time results.",
			fed_bytes, times_checked);
		$display("Offsets spanned +0:00 to +31:63 under sender and receiver gaps.");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/nmea_rmc_pkg.sv
sv/nmea_rmc_local_time_extractor_unit.sv
bench/nmea_rmc_local_time_extractor_unit_test.sv
